// File: sv/b2r_pkg.sv
// Package for the binary to Roman numeral converter.
// Holds field widths, the control word and emit types, and the microcode ROM.
// No dependencies.
package b2r_pkg;

    localparam int VALUE_W   = 12;
    localparam int SYM_W     = 7;
    localparam int WEIGHT_W  = 10;
    localparam int STEP_W    = 4;
    localparam int NUM_STEPS = 13;

    localparam logic [VALUE_W-1:0] MAX_VALUE = VALUE_W'(3999);

    // ASCII letters used in numerals.
    localparam logic [SYM_W-1:0] SYM_NONE = 7'h00;
    localparam logic [SYM_W-1:0] SYM_I    = 7'h49;
    localparam logic [SYM_W-1:0] SYM_V    = 7'h56;
    localparam logic [SYM_W-1:0] SYM_X    = 7'h58;
    localparam logic [SYM_W-1:0] SYM_L    = 7'h4C;
    localparam logic [SYM_W-1:0] SYM_C    = 7'h43;
    localparam logic [SYM_W-1:0] SYM_D    = 7'h44;
    localparam logic [SYM_W-1:0] SYM_M    = 7'h4D;

    // One control word per sequencer step.
    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;     // value subtracted on a match
        logic [SYM_W-1:0]    first;      // letter emitted on a match
        logic [SYM_W-1:0]    second;     // second letter of a two-letter entry
        logic                has_second; // entry emits two letters
        logic [STEP_W-1:0]   next_step;  // jump target when no match
        logic                end_prog;   // no match here ends the program
    } ucode_t;

    // One character offered by the sequencer.
    typedef struct packed {
        logic             valid;
        logic [SYM_W-1:0] symbol;
        logic             last;
        logic             error;
    } emit_t;

    // Microcode ROM, one entry per table weight in descending order.
    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t uc;
        uc = '0;
        unique case (step)
            4'd0:  uc = '{10'd1000, SYM_M, SYM_NONE, 1'b0, 4'd1,  1'b0};
            4'd1:  uc = '{10'd900,  SYM_C, SYM_M,    1'b1, 4'd2,  1'b0};
            4'd2:  uc = '{10'd500,  SYM_D, SYM_NONE, 1'b0, 4'd3,  1'b0};
            4'd3:  uc = '{10'd400,  SYM_C, SYM_D,    1'b1, 4'd4,  1'b0};
            4'd4:  uc = '{10'd100,  SYM_C, SYM_NONE, 1'b0, 4'd5,  1'b0};
            4'd5:  uc = '{10'd90,   SYM_X, SYM_C,    1'b1, 4'd6,  1'b0};
            4'd6:  uc = '{10'd50,   SYM_L, SYM_NONE, 1'b0, 4'd7,  1'b0};
            4'd7:  uc = '{10'd40,   SYM_X, SYM_L,    1'b1, 4'd8,  1'b0};
            4'd8:  uc = '{10'd10,   SYM_X, SYM_NONE, 1'b0, 4'd9,  1'b0};
            4'd9:  uc = '{10'd9,    SYM_I, SYM_X,    1'b1, 4'd10, 1'b0};
            4'd10: uc = '{10'd5,    SYM_V, SYM_NONE, 1'b0, 4'd11, 1'b0};
            4'd11: uc = '{10'd4,    SYM_I, SYM_V,    1'b1, 4'd12, 1'b0};
            4'd12: uc = '{10'd1,    SYM_I, SYM_NONE, 1'b0, 4'd12, 1'b1};
            default: uc = '{10'd1,  SYM_I, SYM_NONE, 1'b0, 4'd12, 1'b1};
        endcase
        return uc;
    endfunction

endpackage

// File: sv/b2r_seq.sv
// Microcoded sequencer and datapath of the Roman numeral converter.
// Steps through the control ROM of b2r_pkg and offers one character at a time.
// Depends on b2r_pkg.
module b2r_seq (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         load,
    input  logic [b2r_pkg::VALUE_W-1:0]  value,
    input  logic                         out_free,
    output logic                         busy,
    output b2r_pkg::emit_t               emit
);
    import b2r_pkg::*;

    logic [VALUE_W-1:0] remainder_reg, remainder_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               pending_reg, pending_next;
    logic               busy_reg, busy_next;
    logic               error_reg, error_next;

    ucode_t             uc;
    logic [VALUE_W-1:0] weight_ext;
    logic [VALUE_W-1:0] diff;
    logic               match;
    logic               done_after;

    // Fetch the control word and run the single compare and subtract.
    always_comb begin
        uc         = ucode_rom(step_reg);
        weight_ext = {{(VALUE_W-WEIGHT_W){1'b0}}, uc.weight};
        match      = (remainder_reg >= weight_ext);
        diff       = remainder_reg - weight_ext;
        done_after = (diff == '0) && !uc.has_second;
    end

    // Sequencer next state and the character offered this cycle.
    always_comb begin
        remainder_next = remainder_reg;
        step_next      = step_reg;
        pending_next   = pending_reg;
        busy_next      = busy_reg;
        error_next     = error_reg;
        emit           = '0;
        if (!busy_reg) begin
            if (load) begin
                remainder_next = value;
                step_next      = '0;
                pending_next   = 1'b0;
                busy_next      = 1'b1;
                error_next     = (value == '0) || (value > MAX_VALUE);
            end
        end else if (error_reg) begin
            emit = '{1'b1, SYM_NONE, 1'b1, 1'b1};
            if (out_free) begin
                busy_next = 1'b0;
            end
        end else if (pending_reg) begin
            emit = '{1'b1, uc.second, (remainder_reg == '0), 1'b0};
            if (out_free) begin
                pending_next = 1'b0;
                busy_next    = (remainder_reg != '0);
            end
        end else if (match) begin
            emit = '{1'b1, uc.first, done_after, 1'b0};
            if (out_free) begin
                remainder_next = diff;
                pending_next   = uc.has_second;
                busy_next      = !done_after;
            end
        end else begin
            // Conditional jump to the next smaller weight, or end of the program on the last step.
            step_next = uc.next_step;
            busy_next = !uc.end_prog;
        end
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remainder_reg <= '0;
            step_reg      <= '0;
            pending_reg   <= 1'b0;
            busy_reg      <= 1'b0;
            error_reg     <= 1'b0;
        end else begin
            remainder_reg <= remainder_next;
            step_reg      <= step_next;
            pending_reg   <= pending_next;
            busy_reg      <= busy_next;
            error_reg     <= error_next;
        end
    end

    assign busy = busy_reg;

endmodule

// File: sv/binary_to_roman_numeral.sv
// Top level of the binary to Roman numeral converter.
// Stream ports, output register and checks; depends on b2r_pkg and b2r_seq.
//
// Usage: each word on the slave channel carries one value in s_tdata[11:0].
// The block answers with the Roman numeral, one ASCII letter per master word
// in m_tdata[6:0]; m_tlast marks the final letter. A value of 0 or above 3999
// gives one word with m_tdata = 0, m_tuser = 1 and m_tlast = 1.
// Operation: a taken value is loaded into a microcoded sequencer, which then
// runs one step per cycle. Each step either emits a letter or jumps past a
// table weight that is too large; a step that emits a letter waits while the
// output register is not free. The first letter passes through the sequencer
// state registers and the output register before it appears at m_tvalid.
// The next value is taken once the last letter of the current one has entered
// the output register, even while that letter still waits there.
// A stall on m_tready holds the output register and freezes the sequencer at
// its next letter; jumps past weights that are too large still go on.
// Reset (aresetn low, synchronous) drops any conversion in flight and empties
// the output register.
module binary_to_roman_numeral (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] value, [15:12] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [6:0] symbol, [7] zero
    output logic        m_tlast,
    output logic        m_tuser    // [0] error
);
    import b2r_pkg::*;

    logic             busy;
    logic             out_free;
    emit_t            emit;
    logic             m_tvalid_reg;
    logic [SYM_W-1:0] symbol_reg;
    logic             last_reg;
    logic             error_reg;

    // Output register is free when empty or being taken.
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = !busy;

    b2r_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (s_tvalid && s_tready),
        .value    (s_tdata[VALUE_W-1:0]),
        .out_free (out_free),
        .busy     (busy),
        .emit     (emit)
    );

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_free) begin
            m_tvalid_reg <= emit.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && emit.valid) begin
            symbol_reg <= emit.symbol;
            last_reg   <= emit.last;
            error_reg  <= emit.error;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, symbol_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = error_reg;

    // An error word is a lone word with no letter.
    a_error_lone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata == 8'h00))
        else $error("error word is not a lone empty word");

    // Every normal word carries a letter.
    a_letter: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (m_tdata[6:0] != 7'h00))
        else $error("normal word without a letter");

    // A taken value always starts a conversion.
    a_busy_after_load: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after a value was taken");

    // A new word never appears when the sequencer is idle and was idle, with no value offered, in the previous cycle.
    a_no_word_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready && !$past(busy) && !($past(s_tvalid)) |-> !(m_tvalid && !$past(m_tvalid)))
        else $error("word appeared with no conversion running");

endmodule
